@@ src/p2rw_pkg.sv @@
// Package for the packed 2-bit-per-pixel row writer: request, response and
// work-stage types, command and operation codes, pixel slot masks.
// No dependencies.
`default_nettype none

package p2rw_pkg;

   // field widths fixed by the interface
   localparam int ADDR_W = 6;
   localparam int POS_W  = 9;

   // request commands
   localparam logic [1:0] CMD_BLIT = 2'd0;
   localparam logic [1:0] CMD_FILL = 2'd1;
   localparam logic [1:0] CMD_READ = 2'd2;

   // configuration register indexes
   localparam logic [1:0] CSR_INK  = 2'd0;
   localparam logic [1:0] CSR_DARK = 2'd1;
   localparam logic [1:0] CSR_PALE = 2'd2;

   // threshold reset values
   localparam logic [7:0] INK_RESET  = 8'd42;
   localparam logic [7:0] DARK_RESET = 8'd127;
   localparam logic [7:0] PALE_RESET = 8'd212;

   // stored pixel levels, inverse to brightness
   localparam logic [1:0] LVL_PAPER = 2'd0;
   localparam logic [1:0] LVL_PALE  = 2'd1;
   localparam logic [1:0] LVL_DARK  = 2'd2;
   localparam logic [1:0] LVL_INK   = 2'd3;

   // operations held in the work stage
   localparam logic [1:0] OP_BLIT = 2'd0;
   localparam logic [1:0] OP_FILL = 2'd1;
   localparam logic [1:0] OP_READ = 2'd2;
   localparam logic [1:0] OP_CLIP = 2'd3;

   // pixel slot masks, leftmost pixel in the high bits
   localparam logic [7:0] MASK_SLOT0 = 8'hc0;
   localparam logic [7:0] MASK_SLOT1 = 8'h30;
   localparam logic [7:0] MASK_SLOT2 = 8'h0c;
   localparam logic [7:0] MASK_SLOT3 = 8'h03;

   typedef struct packed {
      logic [1:0] command;
      logic [7:0] x_position;
      logic [8:0] run_width;
      logic [7:0] luma;
      logic [1:0] fill_value;
      logic       first_pixel;
      logic       last_pixel;
      logic [5:0] read_address;
   } req_type;

   typedef struct packed {
      logic [5:0] byte_address;
      logic [7:0] byte_data;
      logic       last_of_run;
      logic       clipped;
   } rsp_type;

   // one operation in the read-modify-write stage
   typedef struct packed {
      logic [1:0]        kind;
      logic [ADDR_W-1:0] cur;
      logic [1:0]        slot;
      logic [1:0]        val;
      logic              emit;
      logic              clip;
      logic              oor;
      logic [7:0]        fill_x;
      logic [POS_W-1:0]  fill_lim;
      logic [ADDR_W-1:0] last_byte;
   } work_type;

   function automatic logic [7:0] slot_mask(input logic [1:0] slot);
      logic [7:0] m;
      unique case (slot)
         2'd0:    m = MASK_SLOT0;
         2'd1:    m = MASK_SLOT1;
         2'd2:    m = MASK_SLOT2;
         default: m = MASK_SLOT3;
      endcase
      return m;
   endfunction

endpackage

`default_nettype wire

@@ src/packed_2bpp_row_writer_top.sv @@
// Top level of the packed 2-bit-per-pixel row writer: row memory with valid
// bits, read-modify-write stage with forwarding, result register.
// Depends on p2rw_pkg.
//
//   port group   dir   handshake            payload
//   req_         in    req_valid/req_stall  p2rw_pkg::req_type
//   rsp_         out   rsp_valid/rsp_stall  p2rw_pkg::rsp_type
//   csr_         in    csr_write            csr_index, csr_data
//
// A blit or read is taken at one request per cycle, a fill at one byte per cycle
// it touches, unless a full result register stalls; the row memory reads at
// acceptance, writes from the work stage and forwards same-byte reads. Reset clears
// the row valid bits directly: no clearing pass. A full result register under stall
// holds a work-stage operation that has a result to give, and the request side.
`default_nettype none

module packed_2bpp_row_writer_top #(
   parameter int ROW_BYTES = 64
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_stall,
   input  p2rw_pkg::req_type   req_payload,
   output logic                rsp_valid,
   input  wire                 rsp_stall,
   output p2rw_pkg::rsp_type   rsp_payload,
   input  wire                 csr_write,
   input  wire [1:0]           csr_index,
   input  wire [7:0]           csr_data
);
   import p2rw_pkg::*;

   localparam int AW = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;
   localparam logic [POS_W-1:0]  ROW_PIXELS = POS_W'(ROW_BYTES * 4);
   localparam logic [ADDR_W-1:0] LAST_BYTE  = ADDR_W'(ROW_BYTES - 1);
   localparam logic [ADDR_W:0]   ROW_BYTES_W = (ADDR_W + 1)'(ROW_BYTES);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_WORK = 1'b1;

   // thresholds and strip state
   logic [7:0]       ink_thr_ff, ink_thr_in;
   logic [7:0]       dark_thr_ff, dark_thr_in;
   logic [7:0]       pale_thr_ff, pale_thr_in;
   logic [POS_W-1:0] next_position_ff, next_position_in;
   logic             strip_active_ff, strip_active_in;
   logic             state_ff, state_in;
   work_type         work_ff, work_in;

   // row memory and its read side
   logic [7:0]           row_mem [ROW_BYTES];
   logic [ROW_BYTES-1:0] valid_ff;
   logic [7:0]           mem_q_ff;
   logic                 vld_q_ff;
   logic                 fwd_ff;
   logic [7:0]           fwd_data_ff;

   // result register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   // request decode
   logic             accept;
   logic             has_work;
   work_type         new_work;
   logic [POS_W-1:0] pos;
   logic             pos_past;
   logic [POS_W:0]   fill_end;
   logic             fill_clip;
   logic             fill_past_start;
   logic [POS_W-1:0] fill_lim;
   logic [POS_W-1:0] lim_m1;
   logic [1:0]       level;

   // work stage
   logic              fire;
   logic              more;
   logic              done;
   logic              need_out;
   logic              out_space;
   logic              writes;
   logic [7:0]        eff_byte;
   logic [7:0]        mask;
   logic [7:0]        new_byte;
   logic [ADDR_W-1:0] rd_addr;
   logic              rd_en;
   logic [AW-1:0]     rd_idx;
   logic [AW-1:0]     wr_idx;
   logic              wr_en;
   logic [7:0]        pix;

   // handshake
   assign out_space = !rsp_valid_ff || !rsp_stall;
   assign need_out  = (work_ff.kind != OP_BLIT) || work_ff.emit;
   assign more      = (work_ff.kind == OP_FILL) && (work_ff.cur != work_ff.last_byte);
   assign fire      = (state_ff == ST_WORK) && (!need_out || out_space);
   assign done      = fire && !more;
   assign req_stall = !((state_ff == ST_IDLE) || done);
   assign accept    = req_valid && !req_stall;

   // quantize luma to a stored level
   always_comb begin
      if (req_payload.luma <= ink_thr_ff) begin
         level = LVL_INK;
      end else if (req_payload.luma <= dark_thr_ff) begin
         level = LVL_DARK;
      end else if (req_payload.luma <= pale_thr_ff) begin
         level = LVL_PALE;
      end else begin
         level = LVL_PAPER;
      end
   end

   // position and run limits of the incoming request
   always_comb begin
      pos = (req_payload.first_pixel || !strip_active_ff) ?
            {1'b0, req_payload.x_position} : next_position_ff;
      pos_past        = pos >= ROW_PIXELS;
      fill_end        = {2'b00, req_payload.x_position} + {1'b0, req_payload.run_width};
      fill_clip       = fill_end > {1'b0, ROW_PIXELS};
      fill_past_start = {1'b0, req_payload.x_position} >= ROW_PIXELS;
      fill_lim        = fill_clip ? ROW_PIXELS : fill_end[POS_W-1:0];
      lim_m1          = fill_lim - POS_W'(1);
   end

   // build the work-stage operation
   always_comb begin
      new_work           = '0;
      new_work.kind      = OP_CLIP;
      new_work.cur       = LAST_BYTE;
      new_work.fill_x    = req_payload.x_position;
      new_work.fill_lim  = fill_lim;
      new_work.last_byte = lim_m1[7:2];
      has_work           = 1'b1;
      unique case (req_payload.command)
         CMD_BLIT: begin
            if (pos_past) begin
               new_work.clip = 1'b1;
            end else begin
               new_work.kind = OP_BLIT;
               new_work.cur  = pos[7:2];
               new_work.slot = pos[1:0];
               new_work.val  = level;
               new_work.emit = (pos[1:0] == 2'd3) || req_payload.last_pixel;
            end
         end
         CMD_FILL: begin
            if (req_payload.run_width == '0) begin
               has_work = 1'b0;
            end else if (fill_past_start) begin
               new_work.clip = 1'b1;
            end else begin
               new_work.kind = OP_FILL;
               new_work.cur  = req_payload.x_position[7:2];
               new_work.val  = req_payload.fill_value;
               new_work.clip = fill_clip;
            end
         end
         CMD_READ: begin
            new_work.kind = OP_READ;
            new_work.cur  = req_payload.read_address;
            new_work.oor  = {1'b0, req_payload.read_address} >= ROW_BYTES_W;
         end
         default: begin
            has_work = 1'b0;
         end
      endcase
   end

   // control state next values
   always_comb begin
      next_position_in = next_position_ff;
      strip_active_in  = strip_active_ff;
      if (accept && (req_payload.command == CMD_BLIT)) begin
         strip_active_in  = !req_payload.last_pixel;
         next_position_in = pos_past ? ROW_PIXELS : pos + POS_W'(1);
      end

      state_in = state_ff;
      if (accept) begin
         state_in = has_work ? ST_WORK : ST_IDLE;
      end else if (done) begin
         state_in = ST_IDLE;
      end

      work_in = work_ff;
      if (accept) begin
         work_in = new_work;
      end else if (fire && more) begin
         work_in.cur = work_ff.cur + ADDR_W'(1);
      end
   end

   // configuration writes
   always_comb begin
      ink_thr_in  = ink_thr_ff;
      dark_thr_in = dark_thr_ff;
      pale_thr_in = pale_thr_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_INK:  ink_thr_in  = csr_data;
            CSR_DARK: dark_thr_in = csr_data;
            CSR_PALE: pale_thr_in = csr_data;
            default:  ;
         endcase
      end
   end

   // merge the pixel or run into the byte read for this operation
   always_comb begin
      if (work_ff.oor) begin
         eff_byte = '0;
      end else if (fwd_ff) begin
         eff_byte = fwd_data_ff;
      end else if (vld_q_ff) begin
         eff_byte = mem_q_ff;
      end else begin
         eff_byte = '0;
      end

      if (work_ff.kind == OP_FILL) begin
         mask = '0;
         for (int s = 0; s < 4; s++) begin
            pix = {work_ff.cur, 2'(s)};
            if ((pix >= work_ff.fill_x) && ({1'b0, pix} < work_ff.fill_lim)) begin
               mask = mask | slot_mask(2'(s));
            end
         end
      end else begin
         pix  = '0;
         mask = slot_mask(work_ff.slot);
      end

      new_byte = (eff_byte & ~mask) | ({4{work_ff.val}} & mask);
      writes   = (work_ff.kind == OP_BLIT) || (work_ff.kind == OP_FILL);
      wr_en    = fire && writes;
      wr_idx   = work_ff.cur[AW-1:0];
   end

   // memory read address: next fill byte or the new request's byte
   always_comb begin
      rd_addr = (fire && more) ? work_ff.cur + ADDR_W'(1) : new_work.cur;
      rd_en   = accept || (fire && more);
      rd_idx  = rd_addr[AW-1:0];
   end

   // result register
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (fire && need_out) begin
         rsp_valid_in        = 1'b1;
         rsp_in.byte_address = work_ff.cur;
         rsp_in.byte_data    = writes ? new_byte : eff_byte;
         rsp_in.last_of_run  = !more;
         rsp_in.clipped      = work_ff.clip;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ink_thr_ff       <= INK_RESET;
         dark_thr_ff      <= DARK_RESET;
         pale_thr_ff      <= PALE_RESET;
         next_position_ff <= '0;
         strip_active_ff  <= 1'b0;
         state_ff         <= ST_IDLE;
         rsp_valid_ff     <= 1'b0;
         valid_ff         <= '0;
      end else begin
         ink_thr_ff       <= ink_thr_in;
         dark_thr_ff      <= dark_thr_in;
         pale_thr_ff      <= pale_thr_in;
         next_position_ff <= next_position_in;
         strip_active_ff  <= strip_active_in;
         state_ff         <= state_in;
         rsp_valid_ff     <= rsp_valid_in;
         if (wr_en) begin
            valid_ff[wr_idx] <= 1'b1;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      work_ff <= work_in;
      rsp_ff  <= rsp_in;
   end

   // row memory: one write, one registered read, same-byte forwarding
   always_ff @(posedge clock) begin
      if (wr_en) begin
         row_mem[wr_idx] <= new_byte;
      end
      if (rd_en) begin
         mem_q_ff    <= row_mem[rd_idx];
         vld_q_ff    <= valid_ff[rd_idx];
         fwd_ff      <= wr_en && (wr_idx == rd_idx);
         fwd_data_ff <= new_byte;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // no new request while a fill still has bytes to go
   a_no_accept_mid_fill: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WORK && more) |-> !accept)
      else $error("request accepted during a fill run");

   // writes stay inside the row
   a_write_in_row: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> ({1'b0, work_ff.cur} < ROW_BYTES_W))
      else $error("row write beyond the last byte");

   // fill cursor never passes the run's last byte
   a_fill_cursor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WORK && work_ff.kind == OP_FILL) |-> (work_ff.cur <= work_ff.last_byte))
      else $error("fill cursor past last byte");

   // running position never passes the row end
   a_position_bound: assert property (@(posedge clock) disable iff (reset)
      next_position_ff <= ROW_PIXELS)
      else $error("blit position beyond row end");

endmodule

`default_nettype wire
